/* sv/disk_access_time_model_defines.svh */
// ----------------------------------------------------------------------------
// Disk access time model: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DISK_ACCESS_TIME_MODEL_DEFINES_SVH
`define DISK_ACCESS_TIME_MODEL_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every edge outside reset
`define DAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define DAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DAT_ASSERT(lbl, prop, msg)
`define DAT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* sv/dat_pkg.sv */
// ----------------------------------------------------------------------------
// Disk access time model package
// Field widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package dat_pkg;

  // Field widths
  localparam int TIME_W     = 28;
  localparam int CYL_W      = 16;
  localparam int SEC_W      = 10;
  localparam int CNT_W      = 12;
  localparam int RPM_W      = 15;
  localparam int SEEK_W     = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Shared divider: quotient width, divisor width, bits retired per cycle
  localparam int DIV_W         = 28;
  localparam int DIVISOR_W     = 16;
  localparam int DIV_STEP_BITS = 2;
  localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // Shared multiplier operand width
  localparam int MUL_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX   = 28'hFFF_FFFF;
  localparam logic [MUL_W-1:0]  MS_PER_MIN = 16'd60000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPINDLE_RPM       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_SEEK_MS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYLINDER_TOTAL    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = 8'd3;

  // Register reset values
  localparam logic [RPM_W-1:0]  RST_SPINDLE_RPM       = 15'd7200;
  localparam logic [SEEK_W-1:0] RST_AVERAGE_SEEK_MS   = 7'd4;
  localparam logic [CYL_W-1:0]  RST_CYLINDER_TOTAL    = 16'd1024;
  localparam logic [SEC_W-1:0]  RST_SECTORS_PER_TRACK = 10'd64;

  typedef struct packed {
    logic [RPM_W-1:0]  spindle_rpm;
    logic [SEEK_W-1:0] average_seek_ms;
    logic [CYL_W-1:0]  cylinder_total;
    logic [SEC_W-1:0]  sectors_per_track;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* sv/dat_if.sv */
// ----------------------------------------------------------------------------
// Disk access time model channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------

// Request channel
interface dat_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [dat_pkg::CYL_W-1:0]  target_cylinder;
  logic [dat_pkg::SEC_W-1:0]  start_sector;
  logic [dat_pkg::CNT_W-1:0]  sector_count;

  modport source (output valid, opcode, target_cylinder, start_sector, sector_count,
                  input ready);
  modport sink   (input valid, opcode, target_cylinder, start_sector, sector_count,
                  output ready);
endinterface

// Response channel
interface dat_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dat_pkg::TIME_W-1:0]  service_time_ms;

  modport source (output valid, service_time_ms, input ready);
  modport sink   (input valid, service_time_ms, output ready);
endinterface

// Register write channel
interface dat_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dat_pkg::CFG_IDX_W-1:0]   index;
  logic [dat_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/dat_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Disk access time model: configuration registers
// Decodes register write beats into the drive geometry and speed settings.
// ----------------------------------------------------------------------------
module dat_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  dat_cfg_if.sink           cfg_wr,
  output dat_pkg::cfg_t     cfg
);

  dat_pkg::cfg_t cfg_r;
  dat_pkg::cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  // Index decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        dat_pkg::REG_SPINDLE_RPM: begin
          cfg_nxt.spindle_rpm = cfg_wr.data[dat_pkg::RPM_W-1:0];
        end
        dat_pkg::REG_AVERAGE_SEEK_MS: begin
          cfg_nxt.average_seek_ms = cfg_wr.data[dat_pkg::SEEK_W-1:0];
        end
        dat_pkg::REG_CYLINDER_TOTAL: begin
          cfg_nxt.cylinder_total = cfg_wr.data[dat_pkg::CYL_W-1:0];
        end
        dat_pkg::REG_SECTORS_PER_TRACK: begin
          cfg_nxt.sectors_per_track = cfg_wr.data[dat_pkg::SEC_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spindle_rpm       <= dat_pkg::RST_SPINDLE_RPM;
      cfg_r.average_seek_ms   <= dat_pkg::RST_AVERAGE_SEEK_MS;
      cfg_r.cylinder_total    <= dat_pkg::RST_CYLINDER_TOTAL;
      cfg_r.sectors_per_track <= dat_pkg::RST_SECTORS_PER_TRACK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/dat_div.sv */
// ----------------------------------------------------------------------------
// Disk access time model: shared divider
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dat_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dat_pkg::div_req_t   req,
  output dat_pkg::div_rsp_t   rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic [dat_pkg::DIV_CNT_W-1:0]    step_r;
  logic [dat_pkg::DIV_W-1:0]        quo_r;
  logic [dat_pkg::DIVISOR_W-1:0]    rem_r;
  logic [dat_pkg::DIVISOR_W-1:0]    divisor_r;

  logic [dat_pkg::DIV_W-1:0]        quo_nxt;
  logic [dat_pkg::DIVISOR_W-1:0]    rem_nxt;
  logic [dat_pkg::DIVISOR_W:0]      trial;
  logic [dat_pkg::DIVISOR_W:0]      diff;
  logic                             qbit;

  // Two dependent shift/compare/subtract steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    diff    = '0;
    qbit    = 1'b0;
    for (int i = 0; i < dat_pkg::DIV_STEP_BITS; i++) begin
      trial = {rem_nxt, quo_nxt[dat_pkg::DIV_W-1]};
      diff  = trial - {1'b0, divisor_r};
      qbit  = (trial >= {1'b0, divisor_r});
      rem_nxt = qbit ? diff[dat_pkg::DIVISOR_W-1:0] : trial[dat_pkg::DIVISOR_W-1:0];
      quo_nxt = {quo_nxt[dat_pkg::DIV_W-2:0], qbit};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= dat_pkg::DIV_CNT_W'(dat_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

/* sv/disk_access_time_model.sv */
// ----------------------------------------------------------------------------
// Disk access time model
// Service time estimate (seek + rotational delay + transfer) per request,
// with an optional head move.
// ----------------------------------------------------------------------------
// One request is in flight at a time: eight 28-bit divisions on the shared
// two-bit-per-cycle divider, each issued and handed back in turn, three
// products on the shared 16x16 multiplier, then a summing step. A finished
// result waits in the output register while the next request is already
// being accepted and worked on. Register writes are taken at any time but
// are meant for idle periods only.
// ----------------------------------------------------------------------------
`include "disk_access_time_model_defines.svh"

module disk_access_time_model (
  input  logic     clk,
  input  logic     rst_n,
  dat_req_if.sink  in_req,
  dat_rsp_if.source out_rsp,
  dat_cfg_if.sink  cfg_wr
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODA  = 4'd1;
  localparam logic [3:0] S_MODB  = 4'd2;
  localparam logic [3:0] S_MODC  = 4'd3;
  localparam logic [3:0] S_MULG  = 4'd4;
  localparam logic [3:0] S_DIVG1 = 4'd5;
  localparam logic [3:0] S_DIVG2 = 4'd6;
  localparam logic [3:0] S_MULT  = 4'd7;
  localparam logic [3:0] S_DIVT1 = 4'd8;
  localparam logic [3:0] S_DIVT2 = 4'd9;
  localparam logic [3:0] S_MULS  = 4'd10;
  localparam logic [3:0] S_DIVS  = 4'd11;
  localparam logic [3:0] S_SUM   = 4'd12;

  localparam int SEC_EXT = dat_pkg::DIV_W - dat_pkg::SEC_W;
  localparam int CNT_EXT = dat_pkg::DIV_W - dat_pkg::CNT_W;

  dat_pkg::cfg_t     cfg;
  dat_pkg::div_req_t div_req;
  dat_pkg::div_rsp_t div_rsp;

  logic [3:0]                   state_r, state_nxt;
  logic                         issued_r, issued_nxt;
  logic                         op_r, op_nxt;
  logic [dat_pkg::CYL_W-1:0]    cyl_r, cyl_nxt;
  logic [dat_pkg::SEC_W-1:0]    sec_r, sec_nxt;
  logic [dat_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [dat_pkg::CYL_W-1:0]    dist_r, dist_nxt;
  logic [dat_pkg::SEC_W-1:0]    a_r, a_nxt;
  logic [dat_pkg::SEC_W-1:0]    b_r, b_nxt;
  logic [dat_pkg::SEC_W-1:0]    c_r, c_nxt;
  logic [dat_pkg::DIV_W-1:0]    product_r, product_nxt;
  logic [dat_pkg::DIV_W-1:0]    q_r, q_nxt;
  logic [dat_pkg::TIME_W-1:0]   rot_r, rot_nxt;
  logic [dat_pkg::TIME_W-1:0]   xfer_r, xfer_nxt;
  logic [dat_pkg::TIME_W-1:0]   seek_r, seek_nxt;
  logic [dat_pkg::CYL_W-1:0]    head_track_r, head_track_nxt;
  logic [dat_pkg::SEC_W-1:0]    head_sector_r, head_sector_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [dat_pkg::TIME_W-1:0]   out_time_r, out_time_nxt;

  logic                         div_state;
  logic                         spt_zero;
  logic                         rate_zero;
  logic                         sum_fire;
  logic [dat_pkg::SEC_W:0]      gap_raw;
  logic [dat_pkg::SEC_W:0]      gap_wrap;
  logic [dat_pkg::SEC_W-1:0]    gap;
  logic [dat_pkg::SEC_W:0]      end_sum;
  logic [dat_pkg::SEC_W:0]      end_dec;
  logic [dat_pkg::SEC_W:0]      end_wrap;
  logic [dat_pkg::SEC_W-1:0]    end_sector;
  logic [8:0]                   avg3;
  logic [dat_pkg::MUL_W-1:0]    mul_a;
  logic [dat_pkg::MUL_W-1:0]    mul_b;
  logic [2*dat_pkg::MUL_W-1:0]  mul_p;
  logic [dat_pkg::TIME_W+1:0]   total;
  logic [dat_pkg::TIME_W-1:0]   total_sat;

  dat_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  dat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign spt_zero  = (cfg.sectors_per_track == '0);
  assign rate_zero = spt_zero || (cfg.spindle_rpm == '0);

  // Rotational gap: (a - b) mod spt with a, b already reduced
  assign gap_raw  = {1'b0, a_r} + {1'b0, cfg.sectors_per_track} - {1'b0, b_r};
  assign gap_wrap = gap_raw - {1'b0, cfg.sectors_per_track};
  assign gap      = spt_zero ? '0 :
                    (gap_raw >= {1'b0, cfg.sectors_per_track}) ?
                    gap_wrap[dat_pkg::SEC_W-1:0] : gap_raw[dat_pkg::SEC_W-1:0];

  // Last sector covered: (a + c - 1) mod spt, wrapping backwards from zero
  assign end_sum  = {1'b0, a_r} + {1'b0, c_r};
  assign end_dec  = end_sum - 1'b1;
  assign end_wrap = end_dec - {1'b0, cfg.sectors_per_track};
  always_comb begin
    if (spt_zero) begin
      end_sector = '0;
    end else if (end_sum == '0) begin
      end_sector = cfg.sectors_per_track - 1'b1;
    end else if (end_dec >= {1'b0, cfg.sectors_per_track}) begin
      end_sector = end_wrap[dat_pkg::SEC_W-1:0];
    end else begin
      end_sector = end_dec[dat_pkg::SEC_W-1:0];
    end
  end

  // Shared multiplier, result registered into product_r
  assign avg3 = {2'b00, cfg.average_seek_ms} + {1'b0, cfg.average_seek_ms, 1'b0};
  always_comb begin
    case (state_r)
      S_MULG: begin
        mul_a = {{(dat_pkg::MUL_W-dat_pkg::SEC_W){1'b0}}, gap};
        mul_b = dat_pkg::MS_PER_MIN;
      end
      S_MULT: begin
        mul_a = {{(dat_pkg::MUL_W-dat_pkg::CNT_W){1'b0}}, cnt_r};
        mul_b = dat_pkg::MS_PER_MIN;
      end
      default: begin
        mul_a = dist_r;
        mul_b = {{(dat_pkg::MUL_W-9){1'b0}}, avg3};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Sum of the three terms, saturated
  assign total     = {2'b00, seek_r} + {2'b00, rot_r} + {2'b00, xfer_r};
  assign total_sat = (total > {2'b00, dat_pkg::TIME_MAX}) ?
                     dat_pkg::TIME_MAX : total[dat_pkg::TIME_W-1:0];

  assign sum_fire = (state_r == S_SUM) && (!out_valid_r || out_rsp.ready);

  assign div_state = (state_r == S_MODA)  || (state_r == S_MODB)  ||
                     (state_r == S_MODC)  || (state_r == S_DIVG1) ||
                     (state_r == S_DIVG2) || (state_r == S_DIVT1) ||
                     (state_r == S_DIVT2) || (state_r == S_DIVS);

  // Divider operands per state
  always_comb begin
    div_req.start = div_state && !issued_r;
    case (state_r)
      S_MODA: begin
        div_req.dividend = {{SEC_EXT{1'b0}}, sec_r};
        div_req.divisor  = {6'b0, cfg.sectors_per_track};
      end
      S_MODB: begin
        div_req.dividend = {{SEC_EXT{1'b0}}, head_sector_r};
        div_req.divisor  = {6'b0, cfg.sectors_per_track};
      end
      S_MODC: begin
        div_req.dividend = {{CNT_EXT{1'b0}}, cnt_r};
        div_req.divisor  = {6'b0, cfg.sectors_per_track};
      end
      S_DIVG2, S_DIVT2: begin
        div_req.dividend = q_r;
        div_req.divisor  = {1'b0, cfg.spindle_rpm};
      end
      S_DIVS: begin
        div_req.dividend = product_r;
        div_req.divisor  = cfg.cylinder_total;
      end
      default: begin
        div_req.dividend = product_r;
        div_req.divisor  = {6'b0, cfg.sectors_per_track};
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    issued_nxt      = issued_r;
    op_nxt          = op_r;
    cyl_nxt         = cyl_r;
    sec_nxt         = sec_r;
    cnt_nxt         = cnt_r;
    dist_nxt        = dist_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    c_nxt           = c_r;
    product_nxt     = product_r;
    q_nxt           = q_r;
    rot_nxt         = rot_r;
    xfer_nxt        = xfer_r;
    seek_nxt        = seek_r;
    head_track_nxt  = head_track_r;
    head_sector_nxt = head_sector_r;
    out_valid_nxt   = out_valid_r;
    out_time_nxt    = out_time_r;

    // Output register drains independently
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Divider issue/handback
    if (div_state) begin
      if (div_rsp.done) begin
        issued_nxt = 1'b0;
      end else if (!issued_r) begin
        issued_nxt = 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt  = in_req.opcode;
          cyl_nxt = in_req.target_cylinder;
          sec_nxt = in_req.start_sector;
          cnt_nxt = in_req.sector_count;
          dist_nxt = (in_req.target_cylinder >= head_track_r) ?
                     in_req.target_cylinder - head_track_r :
                     head_track_r - in_req.target_cylinder;
          state_nxt = S_MODA;
        end
      end
      S_MODA: begin
        if (div_rsp.done) begin
          a_nxt     = div_rsp.remainder[dat_pkg::SEC_W-1:0];
          state_nxt = S_MODB;
        end
      end
      S_MODB: begin
        if (div_rsp.done) begin
          b_nxt     = div_rsp.remainder[dat_pkg::SEC_W-1:0];
          state_nxt = S_MODC;
        end
      end
      S_MODC: begin
        if (div_rsp.done) begin
          c_nxt     = div_rsp.remainder[dat_pkg::SEC_W-1:0];
          state_nxt = S_MULG;
        end
      end
      S_MULG: begin
        product_nxt = mul_p[dat_pkg::DIV_W-1:0];
        state_nxt   = S_DIVG1;
      end
      S_DIVG1: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quotient;
          state_nxt = S_DIVG2;
        end
      end
      S_DIVG2: begin
        if (div_rsp.done) begin
          rot_nxt   = rate_zero ? '0 : div_rsp.quotient;
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        product_nxt = mul_p[dat_pkg::DIV_W-1:0];
        state_nxt   = S_DIVT1;
      end
      S_DIVT1: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quotient;
          state_nxt = S_DIVT2;
        end
      end
      S_DIVT2: begin
        if (div_rsp.done) begin
          xfer_nxt  = rate_zero ? '0 : div_rsp.quotient;
          state_nxt = S_MULS;
        end
      end
      S_MULS: begin
        product_nxt = mul_p[dat_pkg::DIV_W-1:0];
        state_nxt   = S_DIVS;
      end
      S_DIVS: begin
        if (div_rsp.done) begin
          seek_nxt  = (cfg.cylinder_total == '0) ? '0 : div_rsp.quotient;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // Wait for the output register to free up
        if (sum_fire) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = total_sat;
          if (op_r) begin
            head_track_nxt  = cyl_r;
            head_sector_nxt = end_sector;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      issued_r      <= 1'b0;
      head_track_r  <= '0;
      head_sector_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      issued_r      <= issued_nxt;
      head_track_r  <= head_track_nxt;
      head_sector_r <= head_sector_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cyl_r      <= cyl_nxt;
    sec_r      <= sec_nxt;
    cnt_r      <= cnt_nxt;
    dist_r     <= dist_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    product_r  <= product_nxt;
    q_r        <= q_nxt;
    rot_r      <= rot_nxt;
    xfer_r     <= xfer_nxt;
    seek_r     <= seek_nxt;
    out_time_r <= out_time_nxt;
  end

  assign in_req.ready            = (state_r == S_IDLE);
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.service_time_ms = out_time_r;

  // Checks
  `DAT_ASSERT(a_accept_leaves_idle, in_req.valid && in_req.ready |=> state_r != S_IDLE, "request accepted but sequencer stayed idle")
  `DAT_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `DAT_ASSERT(a_result_from_sum, $rose(out_valid_r) |-> $past(state_r) == S_SUM, "result raised outside the summing step")
  `DAT_ASSERT(a_head_sector_range, sum_fire && op_r && !spt_zero |=> head_sector_r < cfg.sectors_per_track, "head sector out of track range after move")
  `DAT_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

/* dv/dat_tb_pkg.sv */
// ----------------------------------------------------------------------------
// Disk access time model testbench codes
// Request opcodes and the spare register index shared by checker and stimulus.
// ----------------------------------------------------------------------------
package dat_tb_pkg;

  // Request opcodes
  localparam logic OP_ESTIMATE = 1'b0;
  localparam logic OP_MOVE     = 1'b1;

  // Register index with no register behind it
  localparam logic [dat_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

endpackage

/* dv/service_time_checker.sv */
// ----------------------------------------------------------------------------
// Service time checker
// Watches the request, response and register write channels, keeps its own
// copy of the disk geometry and head position, predicts the service time of
// every accepted request and compares each response beat in order.
// ----------------------------------------------------------------------------
module service_time_checker
  import dat_pkg::*;
  import dat_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  logic                  req_opcode,
  input  logic [CYL_W-1:0]      req_cylinder,
  input  logic [SEC_W-1:0]      req_sector,
  input  logic [CNT_W-1:0]      req_count,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  logic [TIME_W-1:0]     rsp_time,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatch_count,
  output int unsigned           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry registers and head position as the block should hold them
  logic [RPM_W-1:0]  spindle_rpm_q;
  logic [SEEK_W-1:0] average_seek_q;
  logic [CYL_W-1:0]  cylinder_total_q;
  logic [SEC_W-1:0]  sectors_per_track_q;
  logic [CYL_W-1:0]  head_track_q;
  logic [SEC_W-1:0]  head_sector_q;

  logic [TIME_W-1:0] expected_times[$];

  // Time to pass a number of sectors under the head; zero divisors give 0
  function automatic longint unsigned sector_time(input longint unsigned sectors);
    if (sectors_per_track_q == '0 || spindle_rpm_q == '0)
      return 0;
    return (sectors * MS_PER_MIN / sectors_per_track_q) / spindle_rpm_q;
  endfunction

  // Seek + rotational delay + transfer, saturated to the result width
  function automatic logic [TIME_W-1:0] service_time(input logic [CYL_W-1:0] cyl,
                                                     input logic [SEC_W-1:0] sec,
                                                     input logic [CNT_W-1:0] cnt);
    longint unsigned distance;
    longint unsigned seek;
    longint unsigned rot_gap;
    longint unsigned total;
    distance = (cyl >= head_track_q) ? cyl - head_track_q : head_track_q - cyl;
    seek     = 0;
    if (cylinder_total_q != '0)
      seek = (64'd3 * average_seek_q * distance) / cylinder_total_q;
    // true modulo, either sector may lie beyond the track
    rot_gap = 0;
    if (sectors_per_track_q != '0)
      rot_gap = (sec % sectors_per_track_q + sectors_per_track_q
                 - head_sector_q % sectors_per_track_q) % sectors_per_track_q;
    total = seek + sector_time(rot_gap) + sector_time(cnt);
    if (total > TIME_MAX)
      return TIME_MAX;
    return total[TIME_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [TIME_W-1:0] want;
    int unsigned       last_sec;
    if (!rst_n) begin
      spindle_rpm_q       = RST_SPINDLE_RPM;
      average_seek_q      = RST_AVERAGE_SEEK_MS;
      cylinder_total_q    = RST_CYLINDER_TOTAL;
      sectors_per_track_q = RST_SECTORS_PER_TRACK;
      head_track_q        = '0;
      head_sector_q       = '0;
      mismatch_count      = 0;
      expected_times.delete();
    end else begin
      // response beat against the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (expected_times.size() == 0) begin
          mismatch_count++;
          $display("%0t: service_time_ms expected none got %0d", $time, rsp_time);
        end else begin
          want = expected_times.pop_front();
          if (rsp_time !== want) begin
            mismatch_count++;
            $display("%0t: service_time_ms expected %0d got %0d", $time, want, rsp_time);
          end
        end
      end
      // request beat: predict with the old head, then move it
      if (req_valid && req_ready) begin
        expected_times.push_back(service_time(req_cylinder, req_sector, req_count));
        if (req_opcode == OP_MOVE) begin
          head_track_q = req_cylinder;
          if (sectors_per_track_q == '0) begin
            head_sector_q = '0;
          end else begin
            // last sector covered; a zero count steps back one sector
            last_sec = (req_sector % sectors_per_track_q + req_count % sectors_per_track_q
                        + sectors_per_track_q - 1) % sectors_per_track_q;
            head_sector_q = last_sec[SEC_W-1:0];
          end
        end
      end
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPINDLE_RPM:       spindle_rpm_q       = cfg_data[RPM_W-1:0];
          REG_AVERAGE_SEEK_MS:   average_seek_q      = cfg_data[SEEK_W-1:0];
          REG_CYLINDER_TOTAL:    cylinder_total_q    = cfg_data[CYL_W-1:0];
          REG_SECTORS_PER_TRACK: sectors_per_track_q = cfg_data[SEC_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_times.size();
  end

endmodule

/* dv/tb_disk_access_time_model.sv */
// ----------------------------------------------------------------------------
// Disk access time model testbench
// Drives directed and random requests through a series of disk geometries,
// including saturation, zero divisors and over-wide register data, with
// random gaps and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_disk_access_time_model;
  import dat_pkg::*;
  import dat_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_MAX      = 13;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 150;

  logic clk;
  logic rst_n;

  dat_req_if req_ch ();
  dat_rsp_if rsp_ch ();
  dat_cfg_if cfg_ch ();

  int unsigned mismatch_count;
  int unsigned pending;
  bit          steady_sender;
  logic [CYL_W-1:0] last_cyl;

  disk_access_time_model dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  service_time_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_ch.valid),
    .req_ready      (req_ch.ready),
    .req_opcode     (req_ch.opcode),
    .req_cylinder   (req_ch.target_cylinder),
    .req_sector     (req_ch.start_sector),
    .req_count      (req_ch.sector_count),
    .rsp_valid      (rsp_ch.valid),
    .rsp_ready      (rsp_ch.ready),
    .rsp_time       (rsp_ch.service_time_ms),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // One request beat after a random gap, or none in steady mode
  task automatic send_request(input logic op, input logic [CYL_W-1:0] cyl,
                              input logic [SEC_W-1:0] sec, input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, IDLE_MAX);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.opcode          <= op;
    req_ch.target_cylinder <= cyl;
    req_ch.start_sector    <= sec;
    req_ch.sector_count    <= cnt;
    last_cyl = cyl;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // New geometry, only once the block has gone idle
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] rpm, input logic [CFG_DATA_W-1:0] seek,
                              input logic [CFG_DATA_W-1:0] cyls, input logic [CFG_DATA_W-1:0] spt);
    wait_for_results();
    write_register(REG_SPINDLE_RPM, rpm);
    write_register(REG_AVERAGE_SEEK_MS, seek);
    write_register(REG_CYLINDER_TOTAL, cyls);
    write_register(REG_SECTORS_PER_TRACK, spt);
  endtask

  // Random geometry, small sizes and zero divisors now and then
  task automatic random_geometry();
    logic [CFG_DATA_W-1:0] rpm;
    logic [CFG_DATA_W-1:0] seek;
    logic [CFG_DATA_W-1:0] cyls;
    logic [CFG_DATA_W-1:0] spt;
    rpm  = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(1, 20000)) :
                                  CFG_DATA_W'($urandom_range(1, 10));
    seek = CFG_DATA_W'($urandom_range(0, 100));
    cyls = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(1, 65535)) :
                                  CFG_DATA_W'($urandom_range(1, 16));
    spt  = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(1, 1023)) :
                                  CFG_DATA_W'($urandom_range(1, 8));
    if ($urandom_range(0, 7) == 0) rpm = '0;
    if ($urandom_range(0, 7) == 0) cyls = '0;
    if ($urandom_range(0, 7) == 0) spt = '0;
    set_geometry(rpm, seek, cyls, spt);
  endtask

  // Random requests mixing full-range, small and edge values
  task automatic random_requests(input int unsigned n);
    logic [CYL_W-1:0] cyl;
    logic [SEC_W-1:0] sec;
    logic [CNT_W-1:0] cnt;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0)
        steady_sender = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: cyl = CYL_W'($urandom_range(0, 65535));
        1: cyl = CYL_W'($urandom_range(0, 1023));
        2: cyl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: cyl = last_cyl + CYL_W'($urandom_range(0, 8));
      endcase
      case ($urandom_range(0, 2))
        0: sec = SEC_W'($urandom_range(0, 1023));
        1: sec = SEC_W'($urandom_range(0, 15));
        default: sec = SEC_W'($urandom_range(1021, 1023));
      endcase
      case ($urandom_range(0, 2))
        0: cnt = CNT_W'($urandom_range(0, 4095));
        1: cnt = CNT_W'($urandom_range(0, 63));
        default: cnt = $urandom_range(0, 1) ? 12'hFFF : 12'(($urandom_range(0, 1)));
      endcase
      send_request($urandom_range(0, 1) ? OP_MOVE : OP_ESTIMATE, cyl, sec, cnt);
    end
  endtask

  // Result side: random stalls, calm stretches and two long hold-offs
  initial begin : result_sink
    int unsigned beats;
    int unsigned stall;
    bit          steady;
    beats  = 0;
    steady = 1'b0;
    rsp_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (beats % 48 == 0)
        steady = ($urandom_range(0, 3) == 0);
      if (beats == 120 || beats == 1000)
        stall = HOLD_CYCLES;
      else if (steady)
        stall = 0;
      else
        stall = $urandom_range(0, IDLE_MAX);
      @(negedge clk);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      beats++;
    end
  end

  // Watchdog on cycles without any beat
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("disk_access_time_model regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n                  = 1'b0;
    steady_sender          = 1'b0;
    last_cyl               = '0;
    req_ch.valid           = 1'b0;
    req_ch.opcode          = OP_ESTIMATE;
    req_ch.target_cylinder = '0;
    req_ch.start_sector    = '0;
    req_ch.sector_count    = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    // held in reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: far seeks, sector beyond the track, zero counts
    send_request(OP_ESTIMATE, 16'd0, 10'd0, 12'd1);
    send_request(OP_MOVE, 16'hFFFF, 10'd1023, 12'hFFF);
    send_request(OP_ESTIMATE, 16'd0, 10'd0, 12'd0);
    send_request(OP_MOVE, 16'd100, 10'd5, 12'd0);
    send_request(OP_ESTIMATE, 16'd100, 10'd3, 12'd1);
    random_requests(200);

    // Slowest spindle, one sector, one cylinder: sum saturates
    set_geometry(16'd1, 16'd127, 16'd1, 16'd1);
    send_request(OP_MOVE, 16'd0, 10'd0, 12'hFFF);
    send_request(OP_ESTIMATE, 16'hFFFF, 10'd1023, 12'hFFF);
    send_request(OP_MOVE, 16'hFFFF, 10'd0, 12'hFFF);
    send_request(OP_ESTIMATE, 16'd0, 10'd1, 12'd1);
    random_requests(150);

    // All divisors zero
    set_geometry(16'd0, 16'd100, 16'd0, 16'd0);
    send_request(OP_MOVE, 16'd300, 10'd900, 12'd7);
    send_request(OP_ESTIMATE, 16'd0, 10'd1023, 12'hFFF);
    random_requests(150);

    // Fast spindle, largest geometry, no seek cost
    set_geometry(16'd20000, 16'd0, 16'hFFFF, 16'd1023);
    send_request(OP_ESTIMATE, 16'hFFFF, 10'd1022, 12'hFFF);
    send_request(OP_MOVE, 16'd1, 10'd1023, 12'd1);
    send_request(OP_ESTIMATE, 16'd1, 10'd0, 12'd1023);
    random_requests(200);

    // Over-wide data on every register and a write to a spare index
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_register(REG_UNUSED, 16'hA5A5);
    send_request(OP_MOVE, 16'hFFFF, 10'd1023, 12'hFFF);
    send_request(OP_ESTIMATE, 16'd0, 10'd0, 12'd1);
    random_requests(200);

    // Random geometries
    for (int p = 0; p < 4; p++) begin
      random_geometry();
      random_requests(210);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("disk_access_time_model regression: pass");
    else
      $display("disk_access_time_model regression: fail");
    $finish;
  end

endmodule
